// ----- rtl/bits_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bits_pkg: shared types and constants for the binary indexed tree sum block
// Store geometry, field widths, request codes and sequencer states.
// ----------------------------------------------------------------------------
package bits_pkg;

  // Store geometry
  localparam int DEPTH   = 1024;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int SIZE_W  = ADDR_W + 1;   // holds DEPTH itself
  localparam int WALK_W  = ADDR_W + 2;   // upward walk can step past DEPTH
  localparam int VAL_W   = 32;

  // Stream widths
  localparam int IN_DATA_W  = 56;        // 10 + 10 + 32 bits, padded to bytes
  localparam int OUT_DATA_W = 32;

  // Request kinds
  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD,
    ST_QRY,
    ST_FIN
  } bits_state_t;

endpackage

// ----- rtl/binary_indexed_tree_sum.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_indexed_tree_sum: Fenwick tree of wrapping signed 32-bit sums
// Point adds and range-sum queries over a 1024-entry node store.
// ----------------------------------------------------------------------------
// After reset the block clears the node store, one entry a cycle, and takes no
// transaction until that pass ends (configuration writes are taken throughout).
// It then works on one request at a time. The single-port-read node memory sets
// the pace: a point add reads one node a cycle while writing back the node read
// the cycle before, along its upward path of at most 11 nodes; a query reads one
// node a cycle along both downward paths, the high end first, at most 20 nodes
// in all. A request with an index at or beyond the active size leaves the store
// alone. The result sits in an output register; the next request is taken as
// soon as the sequencer is idle, and a request finishing while the previous
// result is still held waits for it to be taken.
// ----------------------------------------------------------------------------
module binary_indexed_tree_sum (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration: active_size
  input  logic                            cfg_we,
  input  logic [bits_pkg::SIZE_W-1:0]     cfg_wdata,
  // Request stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [9:0] first_index, [19:10] last_index, [51:20] value, [55:52] zero
  input  logic [bits_pkg::IN_DATA_W-1:0]  in_tdata,
  // [0] req_type
  input  logic                            in_tuser,
  // Result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [31:0] sum
  output logic [bits_pkg::OUT_DATA_W-1:0] out_tdata,
  // [0] index_error
  output logic                            out_tuser
);

  import bits_pkg::*;

  // Node store
  logic [VAL_W-1:0]  mem [DEPTH];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [VAL_W-1:0]  mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [VAL_W-1:0]  rd_data_r;

  // Control registers
  bits_state_t       state_r, state_nxt;
  logic [SIZE_W-1:0] size_cfg_r;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic              pend_r, pend_nxt;
  logic              psub_r, psub_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Datapath registers
  logic [WALK_W-1:0] k_r, k_nxt;
  logic [SIZE_W-1:0] kb_r, kb_nxt;
  logic [ADDR_W-1:0] paddr_r, paddr_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic [VAL_W-1:0]  acc_r, acc_nxt;
  logic              err_r, err_nxt;
  logic [VAL_W-1:0]  out_sum_r, out_sum_nxt;
  logic              out_err_r, out_err_nxt;

  // Request fields
  logic [ADDR_W-1:0] req_first;
  logic [ADDR_W-1:0] req_last;
  logic [VAL_W-1:0]  req_value;
  logic [SIZE_W-1:0] size_eff;
  logic              first_bad;
  logic              last_bad;
  logic [WALK_W-1:0] k_dec;
  logic [WALK_W-1:0] k_low;
  logic [SIZE_W-1:0] kb_dec;

  assign req_first = in_tdata[ADDR_W-1:0];
  assign req_last  = in_tdata[2*ADDR_W-1:ADDR_W];
  assign req_value = in_tdata[2*ADDR_W+VAL_W-1:2*ADDR_W];

  // Effective size saturates at the built depth
  assign size_eff  = (size_cfg_r > SIZE_W'(DEPTH)) ? SIZE_W'(DEPTH) : size_cfg_r;
  assign first_bad = {1'b0, req_first} >= size_eff;
  assign last_bad  = {1'b0, req_last} >= size_eff;

  // Walk helpers: predecessor and lowest set bit
  assign k_dec  = k_r - WALK_W'(1);
  assign k_low  = k_r & (~k_r + WALK_W'(1));
  assign kb_dec = kb_r - SIZE_W'(1);

  // Sequencer: next state, memory control and datapath updates
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    pend_nxt      = 1'b0;
    psub_nxt      = 1'b0;
    k_nxt         = k_r;
    kb_nxt        = kb_r;
    paddr_nxt     = paddr_r;
    val_nxt       = val_r;
    acc_nxt       = acc_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_sum_nxt   = out_sum_r;
    out_err_nxt   = out_err_r;
    mem_we        = 1'b0;
    mem_waddr     = paddr_r;
    mem_wdata     = rd_data_r + val_r;
    mem_re        = 1'b0;
    mem_raddr     = '0;
    in_tready     = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        mem_wdata    = '0;
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          acc_nxt = '0;
          val_nxt = req_value;
          k_nxt   = {2'b00, req_first} + WALK_W'(1);
          kb_nxt  = {1'b0, req_first};
          if (in_tuser == REQ_ADD) begin
            err_nxt   = first_bad;
            state_nxt = first_bad ? ST_FIN : ST_ADD;
          end else begin
            err_nxt   = first_bad || last_bad;
            k_nxt     = {2'b00, req_last} + WALK_W'(1);
            state_nxt = (first_bad || last_bad) ? ST_FIN : ST_QRY;
          end
        end
      end

      // Upward walk: read this node, write back the one read last cycle
      ST_ADD: begin
        mem_we = pend_r;
        if (k_r <= {1'b0, size_eff}) begin
          mem_re    = 1'b1;
          mem_raddr = k_dec[ADDR_W-1:0];
          paddr_nxt = k_dec[ADDR_W-1:0];
          pend_nxt  = 1'b1;
          k_nxt     = k_r + k_low;
        end else if (!pend_r) begin
          state_nxt = ST_FIN;
        end
      end

      // Downward walks: high end adds, low end subtracts
      ST_QRY: begin
        if (pend_r) begin
          acc_nxt = psub_r ? (acc_r - rd_data_r) : (acc_r + rd_data_r);
        end
        if (k_r != '0) begin
          mem_re    = 1'b1;
          mem_raddr = k_dec[ADDR_W-1:0];
          pend_nxt  = 1'b1;
          k_nxt     = k_r & k_dec;
        end else if (kb_r != '0) begin
          mem_re    = 1'b1;
          mem_raddr = kb_dec[ADDR_W-1:0];
          pend_nxt  = 1'b1;
          psub_nxt  = 1'b1;
          kb_nxt    = kb_r & kb_dec;
        end else if (!pend_r) begin
          state_nxt = ST_FIN;
        end
      end

      // Hand the result to the output register once it is free
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = acc_r;
          out_err_nxt   = err_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      size_cfg_r  <= SIZE_W'(DEPTH);
      clr_addr_r  <= '0;
      pend_r      <= 1'b0;
      psub_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      pend_r      <= pend_nxt;
      psub_r      <= psub_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        size_cfg_r <= cfg_wdata;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    k_r       <= k_nxt;
    kb_r      <= kb_nxt;
    paddr_r   <= paddr_nxt;
    val_r     <= val_nxt;
    acc_r     <= acc_nxt;
    err_r     <= err_nxt;
    out_sum_r <= out_sum_nxt;
    out_err_r <= out_err_nxt;
  end

  // Node memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sum_r;
  assign out_tuser  = out_err_r;

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for binary_indexed_tree_sum
// Drives point adds and range-sum queries over the request stream, keeps its
// own copy of the node store and the active size, and checks every result
// transaction in order against the predicted sum and index error flag. Runs a
// directed set, the size extremes, several random size settings, a stretch
// without idling and a phase that repeatedly drains the block.
// ----------------------------------------------------------------------------
module tb;
  import bits_pkg::*;

  typedef struct {
    logic [VAL_W-1:0] sum;
    logic             err;
  } range_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [SIZE_W-1:0]     cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  // Shadow of the node store and the size register
  logic [VAL_W-1:0]  node_sum [DEPTH];
  logic [SIZE_W-1:0] size_reg;

  range_result_t pending_sums [$];
  bit            steady;
  int            fail_count;
  int            n_adds;
  int            n_queries;
  int            n_index_errors;
  int            n_results;
  int            n_sizes;

  binary_indexed_tree_sum DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 2 ns clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Run limit, far above the slowest legal run
  initial begin
    #2_000_000;
    $error("run limit reached with %0d results outstanding", pending_sums.size());
    $display("Mismatches found");
    $finish;
  end

  // Predictor -----------------------------------------------------------------

  function automatic int active_positions();
    return (size_reg > DEPTH) ? DEPTH : int'(size_reg);
  endfunction

  // Sum of positions 0..count-1, walking down by the lowest set bit
  function automatic logic [VAL_W-1:0] prefix_total(int count);
    int               k;
    logic [VAL_W-1:0] acc;
    acc = '0;
    k = count;
    while (k > 0) begin
      if (k <= DEPTH) acc = acc + node_sum[k-1];
      k = k - (k & -k);
    end
    return acc;
  endfunction

  // Applies one request to the shadow store and returns its result
  function automatic range_result_t fenwick_apply(logic req, logic [ADDR_W-1:0] first,
                                                  logic [ADDR_W-1:0] last,
                                                  logic [VAL_W-1:0] amount);
    range_result_t r;
    int            lim;
    int            k;
    lim = active_positions();
    r.sum = '0;
    r.err = 1'b0;
    if (req == REQ_ADD) begin
      if (int'(first) >= lim) begin
        r.err = 1'b1;
      end else begin
        k = int'(first) + 1;
        while (k <= lim) begin
          node_sum[k-1] = node_sum[k-1] + amount;
          k = k + (k & -k);
        end
      end
    end else if (int'(first) >= lim || int'(last) >= lim) begin
      r.err = 1'b1;
    end else begin
      r.sum = prefix_total(int'(last) + 1) - prefix_total(int'(first));
    end
    return r;
  endfunction

  // Stimulus helpers -----------------------------------------------------------

  // Presents one request at a falling edge and holds it until taken
  task automatic send_request(logic req, logic [ADDR_W-1:0] first,
                              logic [ADDR_W-1:0] last, logic [VAL_W-1:0] amount);
    int gap;
    @(negedge clk);
    if (!steady && $urandom_range(99) < 36) begin
      gap = $urandom_range(1, 25);
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = req;
    in_tdata  = {4'b0, amount, last, first};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_sums.push_back(fenwick_apply(req, first, last, amount));
    if (req == REQ_ADD) n_adds++;
    else n_queries++;
  endtask

  // Stops sending and waits for every outstanding result
  task automatic drain_results();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
  endtask

  // Writes active_size while the block is idle
  task automatic set_size(logic [SIZE_W-1:0] size);
    drain_results();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = size;
    @(negedge clk);
    cfg_we    = 1'b0;
    size_reg  = size;
    n_sizes++;
  endtask

  // Mostly legal indices, with both ends of the range and some strays
  function automatic logic [ADDR_W-1:0] pick_index();
    int lim;
    int r;
    lim = active_positions();
    r = $urandom_range(99);
    if (lim == 0 || r < 8) return ADDR_W'($urandom_range(DEPTH - 1));
    if (r < 16) return ADDR_W'(lim - 1);
    if (r < 22) return '0;
    return ADDR_W'($urandom_range(lim - 1));
  endfunction

  function automatic logic [VAL_W-1:0] pick_amount();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 32'h7fff_ffff;
    if (r < 20) return 32'h8000_0000;
    if (r < 25) return 32'hffff_ffff;
    if (r < 50) return $urandom_range(200) - 100;
    return $urandom;
  endfunction

  task automatic send_random_request();
    logic [ADDR_W-1:0] first;
    logic [ADDR_W-1:0] last;
    first = pick_index();
    if ($urandom_range(99) < 45) begin
      send_request(REQ_ADD, first, ADDR_W'($urandom_range(DEPTH - 1)), pick_amount());
    end else begin
      last = pick_index();
      send_request(REQ_QUERY, first, last, $urandom);
    end
  endtask

  // Test tasks -----------------------------------------------------------------

  // Field extremes, wrap-around, empty low end and reversed ranges
  task automatic test_directed_edges();
    set_size(11'd1024);
    send_request(REQ_ADD,   10'd0,    10'd0,    32'h7fff_ffff);
    send_request(REQ_ADD,   10'd1023, 10'd1023, 32'h8000_0000);
    send_request(REQ_ADD,   10'd511,  10'd0,    32'hffff_ffff);
    send_request(REQ_QUERY, 10'd0,    10'd1023, 32'hffff_ffff);
    send_request(REQ_QUERY, 10'd0,    10'd0,    32'h0);
    send_request(REQ_QUERY, 10'd1023, 10'd1023, 32'h5555_aaaa);
    send_request(REQ_QUERY, 10'd1000, 10'd3,    32'h0);
    send_request(REQ_ADD,   10'd0,    10'd682,  32'h7fff_ffff);
    send_request(REQ_QUERY, 10'd0,    10'd0,    32'haaaa_5555);
    send_request(REQ_QUERY, 10'd512,  10'd1022, 32'h0);
  endtask

  // Smallest, zero, saturating and tiny sizes, with index errors
  task automatic test_size_limits();
    set_size(11'd1);
    send_request(REQ_ADD,   10'd0, 10'd0, 32'd5);
    send_request(REQ_ADD,   10'd1, 10'd0, 32'd7);
    send_request(REQ_QUERY, 10'd0, 10'd0, 32'h0);
    send_request(REQ_QUERY, 10'd0, 10'd1, 32'h0);
    send_request(REQ_QUERY, 10'd1, 10'd0, 32'h0);
    set_size(11'd0);
    send_request(REQ_ADD,   10'd0, 10'd0, 32'd9);
    send_request(REQ_QUERY, 10'd0, 10'd0, 32'h0);
    set_size(11'd2047);
    send_request(REQ_QUERY, 10'd0,    10'd1023, 32'h0);
    send_request(REQ_ADD,   10'd1023, 10'd0,    32'hffff_fffb);
    send_request(REQ_QUERY, 10'd1023, 10'd1023, 32'h0);
    set_size(11'd2);
    send_request(REQ_QUERY, 10'd0,    10'd1, 32'h0);
    send_request(REQ_ADD,   10'd1,    10'd0, 32'd3);
    send_request(REQ_QUERY, 10'd1,    10'd1, 32'h0);
    send_request(REQ_ADD,   10'd1023, 10'd0, 32'd1);
  endtask

  // Random traffic under a series of sizes; stored nodes carry across changes
  task automatic test_random_sizes();
    logic [SIZE_W-1:0] sizes [10];
    int                counts [10];
    sizes  = '{11'd1024, 11'd37, 11'd2047, 11'd1, 11'd513, 11'd0, 11'd2,
               11'd1000, 11'd300, 11'd1024};
    counts = '{110, 100, 110, 60, 100, 20, 60, 110, 100, 110};
    sizes[4] = SIZE_W'($urandom_range(3, 1023));
    foreach (sizes[i]) begin
      set_size(sizes[i]);
      repeat (counts[i]) send_random_request();
    end
  endtask

  // Back-to-back requests with both sides always ready
  task automatic test_back_to_back();
    set_size(11'd1024);
    steady = 1'b1;
    repeat (150) send_random_request();
    drain_results();
    steady = 1'b0;
  endtask

  // Sender waits for the block to empty at random points
  task automatic test_drain_pressure();
    set_size(SIZE_W'($urandom_range(64, 1024)));
    repeat (100) begin
      send_random_request();
      if ($urandom_range(99) < 8) drain_results();
    end
  endtask

  // Result checking --------------------------------------------------------

  always @(negedge clk) begin
    out_tready = steady || ($urandom_range(99) >= 36);
  end

  always @(posedge clk) begin : result_check
    range_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_sums.size() == 0) begin
        $error("result transaction with no request outstanding: sum %0d, index_error %0b",
               $signed(out_tdata), out_tuser);
        fail_count++;
      end else begin
        want = pending_sums.pop_front();
        n_results++;
        if (want.err) n_index_errors++;
        if (out_tdata !== want.sum) begin
          $error("sum: expected %0d, got %0d", $signed(want.sum), $signed(out_tdata));
          fail_count++;
        end
        if (out_tuser !== want.err) begin
          $error("index_error: expected %0b, got %0b", want.err, out_tuser);
          fail_count++;
        end
      end
    end
  end

  // Sequence -------------------------------------------------------------------

  initial begin
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = REQ_ADD;
    steady     = 1'b0;
    size_reg   = 11'd1024;
    foreach (node_sum[i]) node_sum[i] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_edges();
    test_size_limits();
    test_random_sizes();
    test_back_to_back();
    test_drain_pressure();

    drain_results();
    repeat (40) @(posedge clk);
    if (pending_sums.size() != 0) begin
      $error("%0d results never arrived", pending_sums.size());
      fail_count++;
    end
    $display("Covered %0d adds and %0d range queries, %0d of them index errors,",
             n_adds, n_queries, n_index_errors);
    $display("over %0d size settings; %0d results checked", n_sizes, n_results);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
